FILE: rtl/core/kig_pkg.sv
package kig_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;
  localparam int RANK_BITS      = 3;

  // Register indices on the configuration port.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_RANK        = 2'd0,
    CFG_LEFT_SHAPE  = 2'd1,
    CFG_RIGHT_SHAPE = 2'd2
  } cfg_reg_t;

  // Values after reset.
  localparam logic [RANK_BITS-1:0]     RANK_RESET  = 3'd1;
  localparam logic [CFG_DATA_BITS-1:0] SHAPE_RESET = 64'h0001_0001_0001_0001;

  // Status of the derived shape tables, handed to the index pipeline.
  typedef struct packed {
    logic settled;
    logic zero;
  } kig_status_t;

endpackage

FILE: rtl/core/kig_stride.sv
module kig_stride #(
  parameter int MAX_RANK   = 4,
  parameter int DIM_BITS   = 16,
  parameter int INDEX_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [kig_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [kig_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output kig_pkg::kig_status_t                   status,
  output logic [MAX_RANK-1:0][INDEX_BITS:0]      ostr,
  output logic [MAX_RANK-1:0][INDEX_BITS-1:0]    lstr,
  output logic [MAX_RANK-1:0][INDEX_BITS-1:0]    rstr,
  output logic [MAX_RANK-1:0][DIM_BITS-1:0]      rdim,
  output logic [INDEX_BITS:0]                    total
);
  import kig_pkg::*;

  localparam int IB     = INDEX_BITS;
  localparam int DB     = DIM_BITS;
  localparam int CW     = (DB > IB + 1) ? DB : IB + 1;
  localparam int SETTLE = MAX_RANK + 3;
  localparam int SW     = $clog2(SETTLE + 1);
  localparam logic [IB:0] BIG = {1'b1, {IB{1'b0}}};

  // Clip a product of clipped values to 2^IB, which stands for "too large".
  function automatic logic [IB:0] clip_mul(input logic [IB:0] a, input logic [IB:0] b);
    logic [2*IB+1:0] prod;
    prod = a * b;
    clip_mul = (prod > {{(IB+1){1'b0}}, BIG}) ? BIG : prod[IB:0];
  endfunction

  function automatic logic [IB:0] clip_dim(input logic [DB-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    clip_dim = (e > CW'(BIG)) ? BIG : e[IB:0];
  endfunction

  logic [RANK_BITS-1:0]     tensor_rank;
  logic [CFG_DATA_BITS-1:0] left_shape;
  logic [CFG_DATA_BITS-1:0] right_shape;
  logic [3:0]               rank_eff;
  logic [MAX_RANK-1:0][DB-1:0] lfield, rfield;
  logic [MAX_RANK-1:0][DB-1:0] ldim;
  logic [MAX_RANK-1:0][IB:0]   pdim;
  logic [SW-1:0]               cnt;
  logic                        zero;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tensor_rank <= RANK_RESET;
      left_shape  <= SHAPE_RESET;
      right_shape <= SHAPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RANK:        tensor_rank <= cfg_data[RANK_BITS-1:0];
        CFG_LEFT_SHAPE:  left_shape  <= cfg_data;
        CFG_RIGHT_SHAPE: right_shape <= cfg_data;
        default: ;
      endcase
    end
  end

  // Rank zero counts as one; larger ranks saturate.
  always_comb begin
    if (tensor_rank == '0) begin
      rank_eff = 4'd1;
    end else if (4'(tensor_rank) > 4'(MAX_RANK)) begin
      rank_eff = 4'(MAX_RANK);
    end else begin
      rank_eff = 4'(tensor_rank);
    end
  end

  // Position k holds field MAX_RANK-1-k; leading unused positions act as size one.
  for (genvar k = 0; k < MAX_RANK; k++) begin : g_field
    localparam int FSH = (MAX_RANK - 1 - k) * DB;
    if (FSH < 64) begin : g_in
      logic [63:0] lsh, rsh;
      assign lsh = left_shape >> FSH;
      assign rsh = right_shape >> FSH;
      assign lfield[k] = lsh[DB-1:0];
      assign rfield[k] = rsh[DB-1:0];
    end else begin : g_out
      assign lfield[k] = '0;
      assign rfield[k] = '0;
    end
  end

  // Stride tables are registered and settle after any write.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RANK; k++) begin
      if (4'(k) + rank_eff >= 4'(MAX_RANK)) begin
        ldim[k] <= lfield[k];
        rdim[k] <= rfield[k];
      end else begin
        ldim[k] <= DB'(1);
        rdim[k] <= DB'(1);
      end
      pdim[k] <= clip_mul(clip_dim(ldim[k]), clip_dim(rdim[k]));
      if (k == MAX_RANK - 1) begin
        ostr[k] <= (IB+1)'(1);
        lstr[k] <= IB'(1);
        rstr[k] <= IB'(1);
      end else begin
        ostr[k] <= clip_mul(ostr[k+1], pdim[k+1]);
        lstr[k] <= IB'(lstr[k+1] * ldim[k+1]);
        rstr[k] <= IB'(rstr[k+1] * rdim[k+1]);
      end
    end
    total <= clip_mul(ostr[0], pdim[0]);
  end

  always_comb begin
    zero = 1'b0;
    for (int k = 0; k < MAX_RANK; k++) begin
      if (ldim[k] == '0 || rdim[k] == '0) begin
        zero = 1'b1;
      end
    end
  end

  // Settling counter, restarted by every configuration write.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      cnt <= '0;
    end else if (cnt != SW'(SETTLE)) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign status.settled = (cnt == SW'(SETTLE));
  assign status.zero    = zero;

endmodule

FILE: rtl/core/kig_digit.sv
module kig_digit #(
  parameter int MAX_RANK   = 4,
  parameter int DIM_BITS   = 16,
  parameter int INDEX_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_v,
  input  logic [INDEX_BITS-1:0]               in_idx,
  input  kig_pkg::kig_status_t                status,
  input  logic [MAX_RANK-1:0][INDEX_BITS:0]   ostr,
  input  logic [MAX_RANK-1:0][INDEX_BITS-1:0] lstr,
  input  logic [MAX_RANK-1:0][INDEX_BITS-1:0] rstr,
  input  logic [MAX_RANK-1:0][DIM_BITS-1:0]   rdim,
  input  logic [INDEX_BITS:0]                 total,
  output logic                                last_v,
  output logic                                last_oor,
  output logic [INDEX_BITS-1:0]               last_x,
  output logic [INDEX_BITS-1:0]               last_y
);
  import kig_pkg::*;

  localparam int IB  = INDEX_BITS;
  localparam int DB  = DIM_BITS;
  localparam int QI  = (DB < IB) ? DB : IB;
  localparam int PER = IB + QI + 1;
  localparam int NST = MAX_RANK * PER;
  localparam int CW  = IB + DB + 2;

  typedef struct packed {
    logic          v;
    logic          oor;
    logic [IB-1:0] rem;
    logic [IB-1:0] n;
    logic [IB-1:0] p;
    logic [IB-1:0] x;
    logic [IB-1:0] y;
  } stage_t;

  stage_t st [0:NST];
  stage_t nx [0:NST];

  // Entry stage: range check against the total element count.
  always_comb begin
    nx[0]     = st[0];
    nx[0].v   = in_v;
    nx[0].oor = status.zero || (!total[IB] && in_idx >= total[IB-1:0]);
    nx[0].rem = in_idx;
    nx[0].n   = '0;
    nx[0].p   = '0;
    nx[0].x   = '0;
    nx[0].y   = '0;
  end

  // Per position: restoring division by the output stride, one quotient bit a stage,
  // then division of that coordinate by the right size, then the accumulate stage.
  for (genvar s = 1; s <= NST; s++) begin : g_stage
    localparam int POS = (s - 1) / PER;
    localparam int O   = (s - 1) % PER;
    if (O < IB) begin : g_outer
      always_comb begin
        logic [IB-1:0] n_in, p_in;
        logic [IB:0]   pp;
        logic [CW-1:0] diff;
        logic          ge;
        nx[s] = st[s-1];
        if (O == 0) begin
          n_in = st[s-1].rem;
          p_in = '0;
        end else begin
          n_in = st[s-1].n;
          p_in = st[s-1].p;
        end
        pp   = {p_in, n_in[IB-1]};
        ge   = CW'(pp) >= CW'(ostr[POS]);
        diff = CW'(pp) - CW'(ostr[POS]);
        nx[s].p = ge ? diff[IB-1:0] : pp[IB-1:0];
        nx[s].n = {n_in[IB-2:0], ge};
      end
    end else if (O < IB + QI) begin : g_inner
      always_comb begin
        logic [IB-1:0] n_in, p_in;
        logic [IB:0]   pp;
        logic [CW-1:0] diff;
        logic          ge;
        nx[s] = st[s-1];
        if (O == IB) begin
          nx[s].rem = st[s-1].p;
          n_in = st[s-1].n << (IB - QI);
          p_in = st[s-1].n >> QI;
        end else begin
          n_in = st[s-1].n;
          p_in = st[s-1].p;
        end
        pp   = {p_in, n_in[IB-1]};
        ge   = CW'(pp) >= CW'(rdim[POS]);
        diff = CW'(pp) - CW'(rdim[POS]);
        nx[s].p = ge ? diff[IB-1:0] : pp[IB-1:0];
        nx[s].n = {n_in[IB-2:0], ge};
      end
    end else begin : g_acc
      always_comb begin
        logic [QI+IB-1:0] ma;
        logic [2*IB-1:0]  mb;
        nx[s] = st[s-1];
        ma = st[s-1].n[QI-1:0] * lstr[POS];
        mb = st[s-1].p * rstr[POS];
        nx[s].x = st[s-1].x + ma[IB-1:0];
        nx[s].y = st[s-1].y + mb[IB-1:0];
      end
    end
  end

  // Stage registers; the whole pipeline moves together.
  always_ff @(posedge clk) begin
    for (int s = 0; s <= NST; s++) begin
      if (rst) begin
        st[s].v <= 1'b0;
      end else if (en) begin
        st[s] <= nx[s];
      end
    end
  end

  assign last_v   = st[NST].v;
  assign last_oor = st[NST].oor;
  assign last_x   = st[NST].x;
  assign last_y   = st[NST].y;

endmodule

FILE: rtl/core/kronecker_index_generator.sv
// Channel | Direction | Handshake               | Payload
// input   | in        | in_valid / in_ready     | output_index
// output  | out       | out_valid / out_ready   | left_index, right_index, out_of_range
// config  | in        | cfg_we                  | cfg_index, cfg_data
//
// One word is accepted per cycle while in_ready is high, through bit-per-stage dividers.
// After reset or any configuration write, in_ready stays low until the stride tables
// settle; it is also low while the skid entry is full.
// An output register with one skid entry lets the pipeline take one more word while
// a result waits; the pipeline then holds until the skid entry drains.
module kronecker_index_generator #(
  parameter int MAX_RANK   = 4,
  parameter int DIM_BITS   = 16,
  parameter int INDEX_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [kig_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [kig_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [INDEX_BITS-1:0]              output_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [INDEX_BITS-1:0]              left_index,
  output logic [INDEX_BITS-1:0]              right_index,
  output logic                               out_of_range
);
  import kig_pkg::*;

  localparam int IB = INDEX_BITS;

  kig_status_t                       status;
  logic [MAX_RANK-1:0][IB:0]         ostr;
  logic [MAX_RANK-1:0][IB-1:0]       lstr, rstr;
  logic [MAX_RANK-1:0][DIM_BITS-1:0] rdim;
  logic [IB:0]                       total;
  logic                              en;
  logic                              last_v, last_oor;
  logic [IB-1:0]                     last_x, last_y;
  logic                              skid_v;
  logic [IB-1:0]                     skid_x, skid_y;
  logic                              skid_oor;
  logic                              take, push;

  kig_stride #(
    .MAX_RANK(MAX_RANK), .DIM_BITS(DIM_BITS), .INDEX_BITS(INDEX_BITS)
  ) u_stride (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .status(status), .ostr(ostr), .lstr(lstr), .rstr(rstr), .rdim(rdim), .total(total)
  );

  // The pipeline advances whenever the skid entry is free.
  assign en       = !skid_v;
  assign in_ready = en && status.settled;

  kig_digit #(
    .MAX_RANK(MAX_RANK), .DIM_BITS(DIM_BITS), .INDEX_BITS(INDEX_BITS)
  ) u_digit (
    .clk(clk), .rst(rst), .en(en), .in_v(in_valid && in_ready), .in_idx(output_index),
    .status(status), .ostr(ostr), .lstr(lstr), .rstr(rstr), .rdim(rdim), .total(total),
    .last_v(last_v), .last_oor(last_oor), .last_x(last_x), .last_y(last_y)
  );

  assign take = out_valid && out_ready;
  assign push = en && last_v;

  // Output register and skid entry; an out-of-range word carries zero indices.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        left_index   <= skid_x;
        right_index  <= skid_y;
        out_of_range <= skid_oor;
        skid_v       <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        left_index   <= last_oor ? '0 : last_x;
        right_index  <= last_oor ? '0 : last_y;
        out_of_range <= last_oor;
        out_valid    <= 1'b1;
      end else begin
        skid_x   <= last_oor ? '0 : last_x;
        skid_y   <= last_oor ? '0 : last_y;
        skid_oor <= last_oor;
        skid_v   <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid) else $error("skid entry full while output register empty");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready) else $error("input taken while stride tables settle");

  a_ready_needs_room: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !skid_v) else $error("input taken while skid entry is full");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_v && take) |=> (out_valid && !skid_v))
    else $error("skid entry not moved to the output register");

endmodule

FILE: dv/kronecker_index_generator_tb.sv
module kronecker_index_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kig_pkg::*;

  localparam int MAX_RANK   = 4;
  localparam int DIM_BITS   = 16;
  localparam int INDEX_BITS = 32;
  // Pipeline depth of the block, with a margin for the output register.
  localparam int PIPE_DEPTH = 1 + MAX_RANK * (INDEX_BITS + DIM_BITS + 1) + 8;

  typedef struct packed {
    logic [INDEX_BITS-1:0] left_idx;
    logic [INDEX_BITS-1:0] right_idx;
    logic                  oor;
  } operand_pair_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_RANK;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [INDEX_BITS-1:0]     output_index = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [INDEX_BITS-1:0]     left_index;
  logic [INDEX_BITS-1:0]     right_index;
  logic                      out_of_range;

  // Local copy of the configuration registers.
  logic [RANK_BITS-1:0]     rank_q  = RANK_RESET;
  logic [CFG_DATA_BITS-1:0] left_q  = SHAPE_RESET;
  logic [CFG_DATA_BITS-1:0] right_q = SHAPE_RESET;

  operand_pair_t pending_pairs[$];
  int            mismatches = 0;
  int            words_sent = 0;
  int            words_seen = 0;
  int            ranges_hit = 0;
  int            configs    = 0;
  bit            stall_free = 1'b0;

  kronecker_index_generator #(
    .MAX_RANK(MAX_RANK), .DIM_BITS(DIM_BITS), .INDEX_BITS(INDEX_BITS)
  ) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .output_index(output_index),
    .out_valid(out_valid), .out_ready(out_ready), .left_index(left_index),
    .right_index(right_index), .out_of_range(out_of_range)
  );

  always #1 clk = ~clk;

  // Saturating 64-bit multiply: bit 64 of the result marks an overflow.
  function automatic logic [64:0] sat_mul64(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    if (p[127:64] != 0) return {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
    return {1'b0, p[63:0]};
  endfunction

  function automatic int eff_rank();
    int r;
    r = int'(rank_q);
    if (r < 1) r = 1;
    if (r > MAX_RANK) r = MAX_RANK;
    return r;
  endfunction

  // Total element count of the product; bit 64 set when it exceeds 64 bits.
  function automatic logic [64:0] product_size();
    logic [64:0] t, m;
    int r;
    r = eff_rank();
    t = {1'b0, 64'd1};
    for (int j = 0; j < r; j++) begin
      m = sat_mul64({48'd0, left_q[j*DIM_BITS +: DIM_BITS]},
                    {48'd0, right_q[j*DIM_BITS +: DIM_BITS]});
      m[64] = m[64] | t[64];
      t = sat_mul64(t[63:0], m[63:0]) | {m[64], 64'd0};
    end
    return t;
  endfunction

  // Splits a product index into left and right operand indices.
  function automatic operand_pair_t kron_split(logic [INDEX_BITS-1:0] idx_in);
    logic [63:0] lsz[MAX_RANK], rsz[MAX_RANK], ostr[MAX_RANK], lstr[MAX_RANK];
    logic [63:0] rstr[MAX_RANK];
    logic        osat[MAX_RANK];
    logic [64:0] pr, st, tot;
    logic [63:0] rem, q, x, y;
    logic        any_zero, sat;
    operand_pair_t res;
    int r;
    r = eff_rank();
    any_zero = 1'b0;
    for (int j = 0; j < r; j++) begin
      lsz[j] = {48'd0, left_q[(r-1-j)*DIM_BITS +: DIM_BITS]};
      rsz[j] = {48'd0, right_q[(r-1-j)*DIM_BITS +: DIM_BITS]};
      if (lsz[j] == 0 || rsz[j] == 0) any_zero = 1'b1;
    end
    res = '{left_idx: '0, right_idx: '0, oor: 1'b1};
    if (any_zero) return res;
    ostr[r-1] = 64'd1;
    osat[r-1] = 1'b0;
    lstr[r-1] = 64'd1;
    rstr[r-1] = 64'd1;
    for (int j = r - 1; j > 0; j--) begin
      pr = sat_mul64(lsz[j], rsz[j]);
      st = sat_mul64(ostr[j], pr[63:0]);
      ostr[j-1] = st[63:0];
      osat[j-1] = osat[j] | pr[64] | st[64];
      lstr[j-1] = lstr[j] * lsz[j];
      rstr[j-1] = rstr[j] * rsz[j];
    end
    pr  = sat_mul64(lsz[0], rsz[0]);
    tot = sat_mul64(ostr[0], pr[63:0]);
    sat = osat[0] | pr[64] | tot[64];
    if (!sat && {32'd0, idx_in} >= tot[63:0]) return res;
    rem = {32'd0, idx_in};
    x = 64'd0;
    y = 64'd0;
    for (int j = 0; j < r; j++) begin
      if (osat[j]) begin
        q = 64'd0;
      end else begin
        q   = rem / ostr[j];
        rem = rem % ostr[j];
      end
      x = x + (q / rsz[j]) * lstr[j];
      y = y + (q % rsz[j]) * rstr[j];
    end
    res.left_idx  = x[INDEX_BITS-1:0];
    res.right_idx = y[INDEX_BITS-1:0];
    res.oor       = 1'b0;
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result stall generator on the output side.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_free) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ready  <= 1'b1;
    end
  end

  // Result checker against the oldest pending expectation.
  always @(posedge clk) begin
    operand_pair_t exp_pair;
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (pending_pairs.size() == 0) begin
        $error("result word with no expectation pending");
        mismatches++;
      end else begin
        exp_pair = pending_pairs.pop_front();
        if (left_index !== exp_pair.left_idx) begin
          $error("left_index expected %0d got %0d", exp_pair.left_idx, left_index);
          mismatches++;
        end
        if (right_index !== exp_pair.right_idx) begin
          $error("right_index expected %0d got %0d", exp_pair.right_idx, right_index);
          mismatches++;
        end
        if (out_of_range !== exp_pair.oor) begin
          $error("out_of_range expected %0b got %0b", exp_pair.oor, out_of_range);
          mismatches++;
        end
      end
    end
  end

  // Sends one word, records its expected result, then idles at random.
  task automatic send_index(logic [INDEX_BITS-1:0] v);
    int gap;
    operand_pair_t exp_pair;
    in_valid     <= 1'b1;
    output_index <= v;
    do @(posedge clk); while (!in_ready);
    exp_pair = kron_split(v);
    pending_pairs.push_back(exp_pair);
    if (exp_pair.oor) ranges_hit++;
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lowers valid and waits until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // Drives one register write; the caller lowers the write enable afterwards.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      CFG_RANK:       rank_q  = v[RANK_BITS-1:0];
      CFG_LEFT_SHAPE: left_q  = v;
      default:        right_q = v;
    endcase
    configs++;
  endtask

  task automatic set_shape(int rank, logic [63:0] lsh, logic [63:0] rsh);
    drain();
    write_reg(CFG_RANK, 64'(rank));
    write_reg(CFG_LEFT_SHAPE, lsh);
    write_reg(CFG_RIGHT_SHAPE, rsh);
    cfg_we <= 1'b0;
  endtask

  // Reset values: a single element, so only index zero is in range.
  task automatic test_reset_values();
    send_index('0);
    send_index(32'd1);
    send_index('1);
  endtask

  // Rank zero, every rank and ranks above the maximum, at index edges.
  task automatic test_rank_sweep();
    logic [64:0] tot;
    for (int rk = 0; rk < 8; rk++) begin
      set_shape(rk, 64'h0002_0003_0001_0004, 64'h0003_0002_0002_0001);
      tot = product_size();
      send_index('0);
      send_index(tot[31:0] - 32'd1);
      send_index(tot[31:0]);
    end
  endtask

  // A zero-sized dimension empties the product.
  task automatic test_zero_dim();
    set_shape(3, 64'h0000_0002_0000_0002, 64'h0000_0002_0002_0002);
    send_index('0);
    send_index(32'd5);
  endtask

  // Full-size fields overflow the strides and the total.
  task automatic test_huge_shapes();
    set_shape(4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_index('0);
    send_index('1);
    send_index(32'h8000_0000);
    set_shape(2, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
    send_index(32'hFFFE_0001);
    send_index('1);
  endtask

  // Random shapes and indices, mostly small shapes so indices land in range.
  task automatic test_random(int n_items);
    logic [64:0] tot;
    logic [63:0] lsh, rsh;
    int          kind, in_phase;
    logic [INDEX_BITS-1:0] v;
    int done;
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 4; k++) begin
        lsh[k*16 +: 16] = 16'($urandom_range(1, 5));
        rsh[k*16 +: 16] = 16'($urandom_range(1, 5));
      end
      if (kind == 0) begin
        lsh = {$urandom, $urandom};
        rsh = {$urandom, $urandom};
      end else if (kind == 1) begin
        lsh[$urandom_range(0, 3)*16 +: 16] = 16'd0;
      end else if (kind == 2) begin
        lsh[15:0] = 16'($urandom);
        rsh[15:0] = 16'($urandom);
      end
      set_shape($urandom_range(0, 7), lsh, rsh);
      tot = product_size();
      stall_free = ($urandom_range(0, 3) == 0);
      in_phase = $urandom_range(60, 140);
      for (int i = 0; i < in_phase && done < n_items; i++) begin
        if (tot[64] || tot[63:0] > 64'hFFFF_FFFF || $urandom_range(0, 9) == 0) v = $urandom;
        else v = 32'($urandom_range(0, tot[31:0] + 2));
        send_index(v);
        done++;
        // Now and then hold the sender back until the block is empty.
        if ($urandom_range(0, 199) == 0) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_pairs.size() != 0);
        end
      end
      stall_free = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_rank_sweep();
    test_zero_dim();
    test_huge_shapes();
    test_random(1500);
    drain();
    if (pending_pairs.size() != 0) begin
      $error("%0d expected words never arrived", pending_pairs.size());
      mismatches++;
    end
    $display("Sent %0d index words (%0d out of range) over %0d register writes;",
             words_sent, ranges_hit, configs);
    $display("checked %0d result words with %0d mismatches.", words_seen, mismatches);
    if (mismatches == 0) begin
      $display("[kronecker_index_generator] OK");
    end else begin
      $display("[kronecker_index_generator] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("[kronecker_index_generator] ERROR");
    $finish;
  end

endmodule

FILE: kronecker_index_generator.f
rtl/core/kig_pkg.sv
rtl/core/kig_stride.sv
rtl/core/kig_digit.sv
rtl/core/kronecker_index_generator.sv
dv/kronecker_index_generator_tb.sv
